// ----- rtl/gmb_pkg.sv -----
package gmb_pkg;

    // Fixed build constants of the meshlet builder
    localparam int VERTS_PER_MESHLET = 64;
    localparam int MESHLET_TRIANGLES = 126;
    localparam int MAP_DEPTH         = 65536;   // one slot-map entry per global vertex
    localparam int IN_DEPTH          = 2;
    localparam int OUT_DEPTH         = 8;

    localparam logic [7:0] UNUSED_SLOT = 8'hFF;

    typedef enum logic [1:0] {
        KIND_VERTEX   = 2'd0,
        KIND_TRIANGLE = 2'd1,
        KIND_DONE     = 2'd2
    } kind_t;

    typedef struct packed {
        logic [15:0] v_a;
        logic [15:0] v_b;
        logic [15:0] v_c;
        logic        last;
    } tri_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] meshlet_number;
        logic [5:0]  local_slot;
        logic [15:0] global_vertex;
        logic [5:0]  slot_a;
        logic [5:0]  slot_b;
        logic [5:0]  slot_c;
        logic [6:0]  used_vertices;
        logic [6:0]  used_triangles;
        logic        run_end;
    } rec_t;

endpackage

// ----- rtl/gmb_fifo.sv -----
module gmb_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/gmb_back.sv -----
module gmb_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_empty,
    input  gmb_pkg::tri_t in_data,
    output logic          in_pop,
    input  logic          out_full,
    output logic          out_push,
    output gmb_pkg::rec_t out_data,
    output logic          ready
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD_A, S_RD_B, S_RD_C, S_EVAL,
        S_PL_A, S_PL_B, S_PL_C, S_TRI, S_DONE, S_WALK
    } state_t;

    localparam int MV = gmb_pkg::VERTS_PER_MESHLET;
    localparam int MT = gmb_pkg::MESHLET_TRIANGLES;

    state_t      state_reg;
    logic [15:0] clr_reg;
    logic [15:0] va_reg, vb_reg, vc_reg;
    logic        last_reg;
    logic        ua_reg, ub_reg, uc_reg;
    logic [5:0]  sa_reg, sb_reg, sc_reg;
    logic [6:0]  vcnt_reg;
    logic [6:0]  tcnt_reg;
    logic [15:0] mnum_reg;
    logic        flush_reg;
    logic [6:0]  idx_reg;
    logic        pend_reg;

    // slot map and vertex list
    logic [7:0]  slot_map [gmb_pkg::MAP_DEPTH];
    logic [15:0] vlist [MV];
    logic [7:0]  map_q;
    logic [15:0] list_q;

    logic        map_we;
    logic [15:0] map_waddr;
    logic [7:0]  map_wdata;
    logic [15:0] map_raddr;
    logic        list_we;
    logic [5:0]  list_waddr;
    logic [15:0] list_wdata;
    logic [5:0]  list_raddr;

    logic        c_unused;
    logic [1:0]  fresh;
    logic        overflow;
    logic        dup_ba;
    logic        dup_ca;
    logic        dup_cb;
    logic        place_b;
    logic        place_c;

    assign c_unused = (map_q == gmb_pkg::UNUSED_SLOT);
    assign fresh    = 2'(ua_reg) + 2'(ub_reg) + 2'(c_unused);
    assign overflow = ({1'b0, vcnt_reg} + 8'(fresh) > 8'(MV))
                   || ({1'b0, tcnt_reg} + 8'd1 > 8'(MT));
    assign dup_ba   = (vb_reg == va_reg) && ua_reg;
    assign dup_ca   = (vc_reg == va_reg) && ua_reg;
    assign dup_cb   = (vc_reg == vb_reg) && ub_reg;
    assign place_b  = ub_reg && !dup_ba;
    assign place_c  = uc_reg && !dup_ca && !dup_cb;

    assign ready = (state_reg != S_CLEAR);

    always_comb
    begin
        in_pop     = 1'b0;
        out_push   = 1'b0;
        out_data   = '0;
        out_data.meshlet_number = mnum_reg;
        map_we     = 1'b0;
        map_waddr  = va_reg;
        map_wdata  = {1'b0, vcnt_reg};
        map_raddr  = va_reg;
        list_we    = 1'b0;
        list_waddr = vcnt_reg[5:0];
        list_wdata = va_reg;
        list_raddr = idx_reg[5:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
                map_wdata = gmb_pkg::UNUSED_SLOT;
            end
            S_IDLE:   in_pop = !in_empty;
            S_RD_A:   map_raddr = va_reg;
            S_RD_B:   map_raddr = vb_reg;
            S_RD_C:   map_raddr = vc_reg;
            S_EVAL:   ;
            S_PL_A:
            begin
                out_data.kind          = gmb_pkg::KIND_VERTEX;
                out_data.local_slot    = vcnt_reg[5:0];
                out_data.global_vertex = va_reg;
                out_push  = ua_reg && !out_full;
                map_we    = out_push;
                list_we   = out_push;
            end
            S_PL_B:
            begin
                out_data.kind          = gmb_pkg::KIND_VERTEX;
                out_data.local_slot    = vcnt_reg[5:0];
                out_data.global_vertex = vb_reg;
                out_push   = place_b && !out_full;
                map_we     = out_push;
                map_waddr  = vb_reg;
                list_we    = out_push;
                list_wdata = vb_reg;
            end
            S_PL_C:
            begin
                out_data.kind          = gmb_pkg::KIND_VERTEX;
                out_data.local_slot    = vcnt_reg[5:0];
                out_data.global_vertex = vc_reg;
                out_push   = place_c && !out_full;
                map_we     = out_push;
                map_waddr  = vc_reg;
                list_we    = out_push;
                list_wdata = vc_reg;
            end
            S_TRI:
            begin
                out_data.kind    = gmb_pkg::KIND_TRIANGLE;
                out_data.slot_a  = sa_reg;
                out_data.slot_b  = sb_reg;
                out_data.slot_c  = sc_reg;
                out_data.run_end = !(last_reg && (vcnt_reg != '0));
                out_push = !out_full;
            end
            S_DONE:
            begin
                out_data.kind           = gmb_pkg::KIND_DONE;
                out_data.used_vertices  = vcnt_reg;
                out_data.used_triangles = tcnt_reg;
                out_data.run_end        = flush_reg;
                out_push = !out_full;
            end
            S_WALK:
            begin
                list_raddr = idx_reg[5:0];
                map_we     = pend_reg;
                map_waddr  = list_q;
                map_wdata  = gmb_pkg::UNUSED_SLOT;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            slot_map[map_waddr] <= map_wdata;
        end
        map_q <= slot_map[map_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            vlist[list_waddr] <= list_wdata;
        end
        list_q <= vlist[list_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            vcnt_reg  <= '0;
            tcnt_reg  <= '0;
            mnum_reg  <= '0;
            flush_reg <= 1'b0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            last_reg  <= 1'b0;
            ua_reg    <= 1'b0;
            ub_reg    <= 1'b0;
            uc_reg    <= 1'b0;
            va_reg    <= '0;
            vb_reg    <= '0;
            vc_reg    <= '0;
            sa_reg    <= '0;
            sb_reg    <= '0;
            sc_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == 16'(gmb_pkg::MAP_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (!in_empty)
                    begin
                        va_reg    <= in_data.v_a;
                        vb_reg    <= in_data.v_b;
                        vc_reg    <= in_data.v_c;
                        last_reg  <= in_data.last;
                        state_reg <= S_RD_A;
                    end
                end
                S_RD_A:   state_reg <= S_RD_B;
                S_RD_B:
                begin
                    ua_reg    <= (map_q == gmb_pkg::UNUSED_SLOT);
                    sa_reg    <= map_q[5:0];
                    state_reg <= S_RD_C;
                end
                S_RD_C:
                begin
                    ub_reg    <= (map_q == gmb_pkg::UNUSED_SLOT);
                    sb_reg    <= map_q[5:0];
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    uc_reg    <= c_unused;
                    sc_reg    <= map_q[5:0];
                    flush_reg <= 1'b0;
                    state_reg <= overflow ? S_DONE : S_PL_A;
                end
                S_PL_A:
                begin
                    if (!ua_reg)
                    begin
                        state_reg <= S_PL_B;
                    end
                    else if (!out_full)
                    begin
                        sa_reg    <= vcnt_reg[5:0];
                        vcnt_reg  <= vcnt_reg + 1'b1;
                        state_reg <= S_PL_B;
                    end
                end
                S_PL_B:
                begin
                    if (!place_b)
                    begin
                        ub_reg    <= 1'b0;
                        if (dup_ba)
                        begin
                            sb_reg <= sa_reg;
                        end
                        state_reg <= S_PL_C;
                    end
                    else if (!out_full)
                    begin
                        sb_reg    <= vcnt_reg[5:0];
                        vcnt_reg  <= vcnt_reg + 1'b1;
                        state_reg <= S_PL_C;
                    end
                end
                S_PL_C:
                begin
                    if (!place_c)
                    begin
                        if (dup_ca)
                        begin
                            sc_reg <= sa_reg;
                        end
                        else if (dup_cb)
                        begin
                            sc_reg <= sb_reg;
                        end
                        state_reg <= S_TRI;
                    end
                    else if (!out_full)
                    begin
                        sc_reg    <= vcnt_reg[5:0];
                        vcnt_reg  <= vcnt_reg + 1'b1;
                        state_reg <= S_TRI;
                    end
                end
                S_TRI:
                begin
                    if (!out_full)
                    begin
                        tcnt_reg <= tcnt_reg + 1'b1;
                        if (last_reg && (vcnt_reg != '0))
                        begin
                            flush_reg <= 1'b1;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_DONE:
                begin
                    if (!out_full)
                    begin
                        idx_reg   <= '0;
                        pend_reg  <= 1'b0;
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    // list entry read first, its map entry cleared in the cycle after
                    pend_reg <= (idx_reg < vcnt_reg);
                    idx_reg  <= idx_reg + 1'b1;
                    if (idx_reg == vcnt_reg)
                    begin
                        vcnt_reg <= '0;
                        tcnt_reg <= '0;
                        if (flush_reg)
                        begin
                            mnum_reg  <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            mnum_reg  <= mnum_reg + 1'b1;
                            // map now holds nothing, so every vertex is fresh
                            ua_reg    <= 1'b1;
                            ub_reg    <= 1'b1;
                            uc_reg    <= 1'b1;
                            state_reg <= S_PL_A;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/greedy_meshlet_builder_unit.sv -----
// Channel   | Handshake               | Payload
// ----------+-------------------------+--------------------------------------------
// triangle  | push / full             | vertex_a, vertex_b, vertex_c, last_triangle
// record    | pop / empty             | record_kind, meshlet_number, local_slot,
//           |                         | global_vertex, slot_a..c, used_vertices,
//           |                         | used_triangles, run_end
//
// A triangle passes through the back end as the queue read, three slot-map
// reads through the single map port, an evaluate step, one placement step
// per vertex whether placed or not, and one triangle record. A meshlet close
// adds a done record and a walk over the vertex list that clears the map,
// one entry per cycle.
// After reset the slot map is cleared entry by entry; full stays high meanwhile.
// Either side may stall freely; a stalled record queue holds the back end.
module greedy_meshlet_builder_unit #(
    parameter int IN_DEPTH  = gmb_pkg::IN_DEPTH,
    parameter int OUT_DEPTH = gmb_pkg::OUT_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] vertex_a,
    input  logic [15:0] vertex_b,
    input  logic [15:0] vertex_c,
    input  logic        last_triangle,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  record_kind,
    output logic [15:0] meshlet_number,
    output logic [5:0]  local_slot,
    output logic [15:0] global_vertex,
    output logic [5:0]  slot_a,
    output logic [5:0]  slot_b,
    output logic [5:0]  slot_c,
    output logic [6:0]  used_vertices,
    output logic [6:0]  used_triangles,
    output logic        run_end
);

    localparam int TW = $bits(gmb_pkg::tri_t);
    localparam int RW = $bits(gmb_pkg::rec_t);

    gmb_pkg::tri_t in_word;
    gmb_pkg::tri_t tri_q;
    gmb_pkg::rec_t rec_in;
    gmb_pkg::rec_t rec_q;
    logic [TW-1:0] tri_bits;
    logic [RW-1:0] rec_bits;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    logic          o_full;
    logic          o_push;
    logic          back_ready;

    assign in_word.v_a  = vertex_a;
    assign in_word.v_b  = vertex_b;
    assign in_word.v_c  = vertex_c;
    assign in_word.last = last_triangle;

    // front: triangle queue, closed while the map clear runs
    assign full = q_full || !back_ready;

    gmb_fifo #(
        .WIDTH (TW),
        .DEPTH (IN_DEPTH)
    ) u_in_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && back_ready),
        .wdata (in_word),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (tri_bits),
        .empty (q_empty)
    );

    assign tri_q = tri_bits;

    gmb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_empty (q_empty),
        .in_data  (tri_q),
        .in_pop   (q_pop),
        .out_full (o_full),
        .out_push (o_push),
        .out_data (rec_in),
        .ready    (back_ready)
    );

    // record queue decouples the back end from the consumer
    gmb_fifo #(
        .WIDTH (RW),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (o_push),
        .wdata (rec_in),
        .full  (o_full),
        .pop   (pop),
        .rdata (rec_bits),
        .empty (empty)
    );

    assign rec_q          = rec_bits;
    assign record_kind    = rec_q.kind;
    assign meshlet_number = rec_q.meshlet_number;
    assign local_slot     = rec_q.local_slot;
    assign global_vertex  = rec_q.global_vertex;
    assign slot_a         = rec_q.slot_a;
    assign slot_b         = rec_q.slot_b;
    assign slot_c         = rec_q.slot_c;
    assign used_vertices  = rec_q.used_vertices;
    assign used_triangles = rec_q.used_triangles;
    assign run_end        = rec_q.run_end;

endmodule

// ----- rtl/gmb_checker.sv -----
module gmb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  record_kind,
    input logic [15:0] meshlet_number,
    input logic [5:0]  slot_a,
    input logic [5:0]  slot_b,
    input logic [5:0]  slot_c,
    input logic [6:0]  used_vertices,
    input logic [6:0]  used_triangles
);

    // done records carry a non-empty meshlet within limits
    a_done_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && record_kind == gmb_pkg::KIND_DONE) |->
        (used_vertices != 7'd0 && used_triangles != 7'd0
         && used_vertices <= 7'(gmb_pkg::VERTS_PER_MESHLET)
         && used_triangles <= 7'(gmb_pkg::MESHLET_TRIANGLES)))
        else $error("done record counts out of range");

    a_slots_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && record_kind != gmb_pkg::KIND_TRIANGLE) |->
        (slot_a == 6'd0 && slot_b == 6'd0 && slot_c == 6'd0))
        else $error("slots set on non-triangle record");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> (empty && full))
        else $error("queue not quiet after reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(record_kind) && $stable(meshlet_number)))
        else $error("stalled record changed");

endmodule

bind greedy_meshlet_builder_unit gmb_checker u_gmb_checker (.*);

// ----- bench/greedy_meshlet_builder_unit_tb.sv -----
module greedy_meshlet_builder_unit_tb;

    // One triangle transfer as queued for the driver
    typedef struct {
        logic [15:0] va;
        logic [15:0] vb;
        logic [15:0] vc;
        logic        last;
    } tri_item_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [15:0] vertex_a;
    logic [15:0] vertex_b;
    logic [15:0] vertex_c;
    logic        last_triangle;
    logic        empty;
    logic        pop;
    logic [1:0]  record_kind;
    logic [15:0] meshlet_number;
    logic [5:0]  local_slot;
    logic [15:0] global_vertex;
    logic [5:0]  slot_a;
    logic [5:0]  slot_b;
    logic [5:0]  slot_c;
    logic [6:0]  used_vertices;
    logic [6:0]  used_triangles;
    logic        run_end;

    greedy_meshlet_builder_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .vertex_a       (vertex_a),
        .vertex_b       (vertex_b),
        .vertex_c       (vertex_c),
        .last_triangle  (last_triangle),
        .empty          (empty),
        .pop            (pop),
        .record_kind    (record_kind),
        .meshlet_number (meshlet_number),
        .local_slot     (local_slot),
        .global_vertex  (global_vertex),
        .slot_a         (slot_a),
        .slot_b         (slot_b),
        .slot_c         (slot_c),
        .used_vertices  (used_vertices),
        .used_triangles (used_triangles),
        .run_end        (run_end)
    );

    // Predictor state: mirrors the block's slot map, vertex list and counters
    logic [7:0]  pred_map [gmb_pkg::MAP_DEPTH];
    logic [15:0] pred_list [gmb_pkg::VERTS_PER_MESHLET];
    int unsigned pred_nverts;
    int unsigned pred_ntris;
    logic [15:0] pred_meshlet;

    tri_item_t     pending_tris [$];
    gmb_pkg::rec_t expected_recs [$];

    int  mismatches;
    bit  hold_pop;        // long receiver stall, raised from the main test sequence
    int  hold_cycles;
    logic full_at_edge;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic gmb_pkg::rec_t blank_rec(gmb_pkg::kind_t k);
        gmb_pkg::rec_t r;
        r = '0;
        r.kind = k;
        r.meshlet_number = pred_meshlet;
        return r;
    endfunction

    // Close the open meshlet: done record, then clear its map entries
    task automatic close_meshlet();
        gmb_pkg::rec_t r;
        r = blank_rec(gmb_pkg::KIND_DONE);
        r.used_vertices  = pred_nverts[6:0];
        r.used_triangles = pred_ntris[6:0];
        expected_recs.push_back(r);
        for (int j = 0; j < pred_nverts; j++)
            pred_map[pred_list[j]] = gmb_pkg::UNUSED_SLOT;
        pred_nverts  = 0;
        pred_ntris   = 0;
        pred_meshlet = pred_meshlet + 16'd1;
    endtask

    task automatic place_vertex(logic [15:0] v);
        gmb_pkg::rec_t r;
        if (pred_map[v] == gmb_pkg::UNUSED_SLOT && pred_nverts < gmb_pkg::VERTS_PER_MESHLET)
        begin
            pred_map[v] = pred_nverts[7:0];
            pred_list[pred_nverts] = v;
            r = blank_rec(gmb_pkg::KIND_VERTEX);
            r.local_slot    = pred_nverts[5:0];
            r.global_vertex = v;
            expected_recs.push_back(r);
            pred_nverts++;
        end
    endtask

    // Work out every record one accepted triangle causes
    task automatic build_records(tri_item_t t);
        int unsigned fresh;
        gmb_pkg::rec_t r;
        fresh = (pred_map[t.va] == gmb_pkg::UNUSED_SLOT)
              + (pred_map[t.vb] == gmb_pkg::UNUSED_SLOT)
              + (pred_map[t.vc] == gmb_pkg::UNUSED_SLOT);
        if (pred_nverts + fresh > gmb_pkg::VERTS_PER_MESHLET
            || pred_ntris + 1 > gmb_pkg::MESHLET_TRIANGLES)
            close_meshlet();
        place_vertex(t.va);
        place_vertex(t.vb);
        place_vertex(t.vc);
        r = blank_rec(gmb_pkg::KIND_TRIANGLE);
        r.slot_a = pred_map[t.va][5:0];
        r.slot_b = pred_map[t.vb][5:0];
        r.slot_c = pred_map[t.vc][5:0];
        expected_recs.push_back(r);
        pred_ntris++;
        if (t.last && pred_nverts > 0)
        begin
            close_meshlet();
            pred_meshlet = '0;
        end
        expected_recs[expected_recs.size() - 1].run_end = 1'b1;
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 5)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic drive_item(tri_item_t t);
        push          <= 1'b1;
        vertex_a      <= t.va;
        vertex_b      <= t.vb;
        vertex_c      <= t.vc;
        last_triangle <= t.last;
    endtask

    // Driver: offers queued triangles, inputs change on the falling edge
    int send_gap;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else if (push && !full_at_edge)
        begin
            // previous offer taken at the last rising edge
            void'(pending_tris.pop_front());
            send_gap = gap_len();
            if (send_gap == 0 && pending_tris.size() > 0)
                drive_item(pending_tris[0]);
            else
                push <= 1'b0;
        end
        else if (!push)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (pending_tris.size() > 0)
                drive_item(pending_tris[0]);
        end
    end

    // Handshake sampled at the rising edge; prediction runs on the transfer
    always @(posedge clk)
    begin
        full_at_edge <= full;
        if (rst_n && push && !full)
            build_records('{vertex_a, vertex_b, vertex_c, last_triangle});
    end

    // Receiver: random pop gaps plus the long hold
    int recv_gap;
    always @(negedge clk)
    begin
        if (!rst_n || hold_pop)
            pop <= 1'b0;
        else if (recv_gap > 0)
        begin
            recv_gap--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
            recv_gap = gap_len();
        end
    end

    // Monitor: compare each record transfer with the oldest expectation
    always @(posedge clk)
    begin
        gmb_pkg::rec_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_recs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected record kind=%0d meshlet=%0d", record_kind,
                             meshlet_number);
            end
            else
            begin
                want = expected_recs.pop_front();
                if (record_kind !== want.kind || meshlet_number !== want.meshlet_number
                    || local_slot !== want.local_slot || global_vertex !== want.global_vertex
                    || slot_a !== want.slot_a || slot_b !== want.slot_b
                    || slot_c !== want.slot_c || used_vertices !== want.used_vertices
                    || used_triangles !== want.used_triangles || run_end !== want.run_end)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("record mismatch: exp k%0d m%0d s%0d g%0d t%0d/%0d/%0d",
                                 want.kind, want.meshlet_number, want.local_slot,
                                 want.global_vertex, want.slot_a, want.slot_b, want.slot_c);
                        $display("    exp u%0d/%0d e%0d", want.used_vertices,
                                 want.used_triangles, want.run_end);
                        $display("    got k%0d m%0d s%0d g%0d t%0d/%0d/%0d u%0d/%0d e%0d",
                                 record_kind, meshlet_number, local_slot, global_vertex,
                                 slot_a, slot_b, slot_c, used_vertices, used_triangles,
                                 run_end);
                    end
                end
            end
        end
    end

    function automatic tri_item_t mk(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                     logic l);
        tri_item_t t;
        t.va = a;
        t.vb = b;
        t.vc = c;
        t.last = l;
        return t;
    endfunction

    // Random mesh: vertices drawn from a small window so they get reused
    task automatic queue_mesh(int ntris, int span);
        int base;
        base = $urandom_range(0, 65535);
        for (int i = 0; i < ntris; i++)
            pending_tris.push_back(mk(16'(base + $urandom_range(0, span)),
                                      16'(base + $urandom_range(0, span)),
                                      16'(base + $urandom_range(0, span)),
                                      i == ntris - 1));
    endtask

    initial
    begin
        int n;
        push = 1'b0;
        pop = 1'b0;
        vertex_a = '0;
        vertex_b = '0;
        vertex_c = '0;
        last_triangle = 1'b0;
        hold_pop = 1'b0;
        mismatches = 0;
        send_gap = 0;
        recv_gap = 0;
        pred_nverts = 0;
        pred_ntris = 0;
        pred_meshlet = '0;
        for (int i = 0; i < gmb_pkg::MAP_DEPTH; i++)
            pred_map[i] = gmb_pkg::UNUSED_SLOT;

        // Directed: extremes, repeated vertices, a one-triangle mesh
        pending_tris.push_back(mk(16'h0000, 16'hffff, 16'h0000, 1'b0));
        pending_tris.push_back(mk(16'hffff, 16'hffff, 16'hffff, 1'b0));
        pending_tris.push_back(mk(16'haaaa, 16'h5555, 16'h1234, 1'b1));
        pending_tris.push_back(mk(16'h0007, 16'h0008, 16'h0009, 1'b1));
        // Vertex overflow: fresh triples force a close at 63 vertices
        for (int i = 0; i < 22; i++)
            pending_tris.push_back(mk(16'(100 + 3 * i), 16'(101 + 3 * i), 16'(102 + 3 * i),
                                      i == 21));

        // Triangle overflow: 130 triangles over four vertices
        for (int i = 0; i < 130; i++)
            pending_tris.push_back(mk(16'(i % 4), 16'((i + 1) % 4), 16'((i + 2) % 4),
                                      i == 129));
        // Random meshes of varied size and reuse
        n = 0;
        while (n < 180)
        begin
            int m;
            m = $urandom_range(1, 24);
            queue_mesh(m, $urandom_range(2, 120));
            n += m;
        end
        // Noise: unrelated indices, random last flags
        for (int i = 0; i < 20; i++)
            pending_tris.push_back(mk(16'($urandom), 16'($urandom), 16'($urandom),
                                      1'($urandom)));
        pending_tris.push_back(mk(16'd1, 16'd2, 16'd3, 1'b1));

        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_tris.size() < 300);
        // Long receiver hold while the sender keeps offering
        hold_pop = 1'b1;
        hold_cycles = 0;
        while (hold_cycles < 300)
        begin
            @(posedge clk);
            hold_cycles++;
        end
        hold_pop = 1'b0;

        wait (pending_tris.size() == 0 && !push);
        wait (expected_recs.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_recs.size() == 0)
            $display("greedy_meshlet_builder_unit_tb: clean");
        else
            $display("greedy_meshlet_builder_unit_tb: errors");
        $finish;
    end

    // Watchdog: map clear after reset plus the whole run, many times over
    initial
    begin
        #2000000;
        $display("greedy_meshlet_builder_unit_tb: errors");
        $finish;
    end

endmodule

// ----- greedy_meshlet_builder_unit.f -----
rtl/gmb_pkg.sv
rtl/gmb_fifo.sv
rtl/gmb_back.sv
rtl/greedy_meshlet_builder_unit.sv
rtl/gmb_checker.sv
bench/greedy_meshlet_builder_unit_tb.sv
